>>> src/dnd_pkg.sv
package dnd_pkg;

    localparam int MESSAGE_BYTES    = 512;
    localparam int MAX_NAME_LENGTH  = 255;
    localparam int MAX_POINTER_HOPS = 16;

    localparam int ADDR_W   = 9;
    localparam int LEN_W    = 10;
    localparam int CUR_W    = 14;
    localparam int HOP_W    = 5;
    localparam int NLEN_W   = 8;
    localparam int CHUNK_W  = 64;
    localparam int CBYTES_W = 4;
    localparam int STAT_W   = 3;

    localparam logic       OP_WRITE  = 1'b0;
    localparam logic       OP_EXPAND = 1'b1;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    localparam logic [1:0] FMT_LABEL   = 2'b00;
    localparam logic [1:0] FMT_POINTER = 2'b11;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_PAST_END = 3'd1,
        ST_RESERVED = 3'd2,
        ST_HOPS     = 3'd3,
        ST_TOO_LONG = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_HDR,
        S_EV_HDR,
        S_EV_PTR,
        S_EV_CHR,
        S_DOT,
        S_FINISH
    } t_state;

endpackage

>>> src/dnd_if.sv
interface dnd_in_if import dnd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic [7:0]        byte_value;
    logic [LEN_W-1:0]  message_length;

    modport source (
        output valid, operation, address, byte_value, message_length,
        input  ready
    );
    modport sink (
        input  valid, operation, address, byte_value, message_length,
        output ready
    );
endinterface

interface dnd_out_if import dnd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CHUNK_W-1:0]  name_chunk;
    logic [CBYTES_W-1:0] chunk_bytes;
    logic                last;
    logic [STAT_W-1:0]   status;
    logic [LEN_W-1:0]    end_offset;
    logic [NLEN_W-1:0]   name_length;

    modport source (
        output valid, name_chunk, chunk_bytes, last, status, end_offset, name_length,
        input  ready
    );
    modport sink (
        input  valid, name_chunk, chunk_bytes, last, status, end_offset, name_length,
        output ready
    );
endinterface

>>> src/dnd_ram.sv
module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/dns_name_decompressor.sv
// A write beat stores one message byte; an expand beat walks the name from the
// given address through labels and compression pointers up to the closing zero
// label; the walk reads message bytes one at a time through the single read port
// of the message store, and no new beat is accepted until the walk has closed.
// Results leave through a one-entry output register; a full chunk waits for it.
// Reset (synchronous, active low) clears control and the output valid flag; the
// message store is not cleared and must be written before it is expanded.
module dns_name_decompressor import dnd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dnd_in_if.sink    i_item,
    dnd_out_if.source o_result
);
    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [CUR_W-1:0]    r_cursor, n_cursor;
    logic [LEN_W-1:0]    r_resume, n_resume;
    logic                r_have_end, n_have_end;
    logic [HOP_W-1:0]    r_hops, n_hops;
    logic [5:0]          r_hi, n_hi;
    logic [5:0]          r_remain, n_remain;
    logic [CHUNK_W-1:0]  r_pack, n_pack;
    logic [NLEN_W-1:0]   r_nlen, n_nlen;
    t_status             r_status, n_status;

    logic                r_ovalid;
    logic [CHUNK_W-1:0]  r_ochunk;
    logic [CBYTES_W-1:0] r_obytes;
    logic                r_olast;
    t_status             r_ostatus;
    logic [LEN_W-1:0]    r_oend;
    logic [NLEN_W-1:0]   r_onlen;

    logic                push;
    logic [CHUNK_W-1:0]  push_chunk;
    logic [CBYTES_W-1:0] push_bytes;
    logic                push_last;
    t_status             push_status;
    logic [LEN_W-1:0]    push_end;
    logic [NLEN_W-1:0]   push_nlen;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [7:0]          rdata;

    logic                accept, out_free, stall, emit;
    logic [7:0]          emit_char;
    logic [2:0]          pos;
    logic [5:0]          lab;
    logic [CUR_W:0]      cur_p1, cur_lab, len_ext;
    logic [NLEN_W:0]     name_sum;
    logic [CHUNK_W-1:0]  packed_word;

    assign accept = i_item.valid && i_item.ready;
    assign ram_we = accept && (i_item.operation == OP_WRITE);

    dnd_ram #(
        .WIDTH(8),
        .DEPTH(MESSAGE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_item.address),
        .i_wdata (i_item.byte_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign out_free     = !r_ovalid || o_result.ready;
    assign pos          = r_nlen[2:0];
    assign stall        = (pos == 3'd7) && !out_free;
    assign lab          = rdata[5:0];
    assign cur_p1       = {1'b0, r_cursor} + (CUR_W+1)'(1);
    assign cur_lab      = {1'b0, r_cursor} + (CUR_W+1)'(lab);
    assign len_ext      = (CUR_W+1)'(r_len);
    assign name_sum     = {1'b0, r_nlen} + (NLEN_W+1)'(lab) + (NLEN_W+1)'(1);

    always_comb begin
        packed_word = r_pack;
        packed_word[{pos, 3'b000} +: 8] = emit_char;
    end

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_cursor   = r_cursor;
        n_resume   = r_resume;
        n_have_end = r_have_end;
        n_hops     = r_hops;
        n_hi       = r_hi;
        n_remain   = r_remain;
        n_pack     = r_pack;
        n_nlen     = r_nlen;
        n_status   = r_status;
        ram_re     = 1'b0;
        ram_raddr  = r_cursor[ADDR_W-1:0];
        emit       = 1'b0;
        emit_char  = CHAR_DOT;
        push        = 1'b0;
        push_chunk  = '0;
        push_bytes  = '0;
        push_last   = 1'b0;
        push_status = ST_OK;
        push_end    = '0;
        push_nlen   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept && (i_item.operation == OP_EXPAND)) begin
                    n_len      = (i_item.message_length > LEN_W'(MESSAGE_BYTES)) ?
                                 LEN_W'(MESSAGE_BYTES) : i_item.message_length;
                    n_cursor   = CUR_W'(i_item.address);
                    n_resume   = '0;
                    n_have_end = 1'b0;
                    n_hops     = '0;
                    n_pack     = '0;
                    n_nlen     = '0;
                    n_status   = ST_OK;
                    n_state    = S_RD_HDR;
                end
            end
            S_RD_HDR: begin
                if ({1'b0, r_cursor} >= len_ext) begin
                    n_status = ST_PAST_END;
                    n_state  = S_FINISH;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_EV_HDR;
                end
            end
            S_EV_HDR: begin
                if (rdata[7:6] == FMT_POINTER) begin
                    if (cur_p1 >= len_ext) begin
                        n_status = ST_PAST_END;
                        n_state  = S_FINISH;
                    end else if (r_hops >= HOP_W'(MAX_POINTER_HOPS)) begin
                        n_status = ST_HOPS;
                        n_state  = S_FINISH;
                    end else begin
                        if (!r_have_end) begin
                            n_resume   = LEN_W'(cur_p1 + (CUR_W+1)'(1));
                            n_have_end = 1'b1;
                        end
                        n_hops    = r_hops + HOP_W'(1);
                        n_hi      = rdata[5:0];
                        ram_re    = 1'b1;
                        ram_raddr = cur_p1[ADDR_W-1:0];
                        n_state   = S_EV_PTR;
                    end
                end else if (rdata[7:6] != FMT_LABEL) begin
                    n_status = ST_RESERVED;
                    n_state  = S_FINISH;
                end else if (lab == 6'd0) begin
                    if (!r_have_end) begin
                        n_resume   = LEN_W'(cur_p1);
                        n_have_end = 1'b1;
                    end
                    n_status = ST_OK;
                    n_state  = S_FINISH;
                end else if (cur_lab >= len_ext) begin
                    n_status = ST_PAST_END;
                    n_state  = S_FINISH;
                end else if (name_sum > (NLEN_W+1)'(MAX_NAME_LENGTH)) begin
                    n_status = ST_TOO_LONG;
                    n_state  = S_FINISH;
                end else begin
                    n_remain  = lab;
                    ram_re    = 1'b1;
                    ram_raddr = cur_p1[ADDR_W-1:0];
                    n_cursor  = cur_p1[CUR_W-1:0];
                    n_state   = S_EV_CHR;
                end
            end
            S_EV_PTR: begin
                n_cursor = {r_hi, rdata};
                n_state  = S_RD_HDR;
            end
            S_EV_CHR: begin
                emit      = 1'b1;
                emit_char = rdata;
                if (!stall) begin
                    n_cursor = cur_p1[CUR_W-1:0];
                    if (r_remain == 6'd1) begin
                        n_state = S_DOT;
                    end else begin
                        n_remain  = r_remain - 6'd1;
                        ram_re    = 1'b1;
                        ram_raddr = cur_p1[ADDR_W-1:0];
                    end
                end
            end
            S_DOT: begin
                emit      = 1'b1;
                emit_char = CHAR_DOT;
                if (!stall) begin
                    n_state = S_RD_HDR;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    push        = 1'b1;
                    push_chunk  = r_pack;
                    push_bytes  = CBYTES_W'(pos);
                    push_last   = 1'b1;
                    push_status = r_status;
                    push_end    = (r_status == ST_OK) ? r_resume : '0;
                    push_nlen   = r_nlen;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit && !stall) begin
            n_nlen = r_nlen + NLEN_W'(1);
            if (pos == 3'd7) begin
                push       = 1'b1;
                push_chunk = packed_word;
                push_bytes = CBYTES_W'(8);
                n_pack     = '0;
            end else begin
                n_pack = packed_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_cursor   <= '0;
            r_resume   <= '0;
            r_have_end <= 1'b0;
            r_hops     <= '0;
            r_remain   <= '0;
            r_pack     <= '0;
            r_nlen     <= '0;
            r_status   <= ST_OK;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_cursor   <= n_cursor;
            r_resume   <= n_resume;
            r_have_end <= n_have_end;
            r_hops     <= n_hops;
            r_remain   <= n_remain;
            r_pack     <= n_pack;
            r_nlen     <= n_nlen;
            r_status   <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ochunk  <= push_chunk;
            r_obytes  <= push_bytes;
            r_olast   <= push_last;
            r_ostatus <= push_status;
            r_oend    <= push_end;
            r_onlen   <= push_nlen;
        end
    end

    assign o_result.valid       = r_ovalid;
    assign o_result.name_chunk  = r_ochunk;
    assign o_result.chunk_bytes = r_obytes;
    assign o_result.last        = r_olast;
    assign o_result.status      = r_ostatus;
    assign o_result.end_offset  = r_oend;
    assign o_result.name_length = r_onlen;
endmodule

>>> bench/tb_dns_name_decompressor.sv
module tb_dns_name_decompressor;
    import dnd_pkg::*;

    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        val;
        logic [LEN_W-1:0]  mlen;
    } t_msg_op;

    typedef struct {
        logic [CHUNK_W-1:0]  chunk;
        logic [CBYTES_W-1:0] nbytes;
        logic                last;
        logic [STAT_W-1:0]   status;
        logic [LEN_W-1:0]    end_off;
        logic [NLEN_W-1:0]   nlen;
    } t_name_beat;

    logic i_clk;
    logic i_rst_n;

    dnd_in_if  in_bus ();
    dnd_out_if out_bus ();

    dns_name_decompressor uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_bus),
        .o_result (out_bus)
    );

    t_msg_op    msg_ops[$];
    t_msg_op    cur_op;
    t_name_beat expected_chunks[$];
    t_name_beat got_beat;
    t_name_beat want_beat;
    int         known_names[$];

    logic [7:0]         msg_mem [MESSAGE_BYTES];
    logic [CHUNK_W-1:0] pack_word;
    int                 name_len;

    int   src_idle_pct;
    int   snk_idle_pct;
    logic hold_off;
    int   items_queued;
    int   errors;
    int   writes_seen;
    int   expands_seen;
    int   beats_checked;
    int   status_seen [8];

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic void push_expected(logic [CHUNK_W-1:0] chunk, int nbytes, logic last,
                                          t_status st, int eoff, int nlen);
        t_name_beat e;
        e.chunk   = chunk;
        e.nbytes  = CBYTES_W'(nbytes);
        e.last    = last;
        e.status  = st;
        e.end_off = LEN_W'(eoff);
        e.nlen    = NLEN_W'(nlen);
        expected_chunks.push_back(e);
    endfunction

    function automatic void append_char(logic [7:0] c);
        pack_word[8*(name_len % 8) +: 8] = c;
        name_len = (name_len + 1) % 256;
        if (name_len % 8 == 0) begin
            push_expected(pack_word, 8, 1'b0, ST_OK, 0, 0);
            pack_word = '0;
        end
    endfunction

    function automatic void predict_walk(logic [ADDR_W-1:0] start, logic [LEN_W-1:0] mlen);
        int         lim;
        int         cur;
        int         hops;
        int         resume;
        int         lab;
        bit         have_end;
        t_status    st;
        logic [7:0] b;
        lim       = (mlen > MESSAGE_BYTES) ? MESSAGE_BYTES : int'(mlen);
        cur       = start;
        hops      = 0;
        resume    = 0;
        have_end  = 1'b0;
        st        = ST_OK;
        pack_word = '0;
        name_len  = 0;
        forever begin
            if (cur >= lim) begin
                st = ST_PAST_END;
                break;
            end
            b = msg_mem[cur];
            if (b[7:6] == FMT_POINTER) begin
                if (cur + 1 >= lim) begin
                    st = ST_PAST_END;
                    break;
                end
                if (hops >= MAX_POINTER_HOPS) begin
                    st = ST_HOPS;
                    break;
                end
                if (!have_end) begin
                    resume   = cur + 2;
                    have_end = 1'b1;
                end
                hops++;
                cur = {b[5:0], msg_mem[cur + 1]};
                continue;
            end
            if (b[7:6] != FMT_LABEL) begin
                st = ST_RESERVED;
                break;
            end
            lab = b[5:0];
            if (lab == 0) begin
                if (!have_end) resume = cur + 1;
                break;
            end
            if (cur + lab >= lim) begin
                st = ST_PAST_END;
                break;
            end
            if (name_len + lab + 1 > MAX_NAME_LENGTH) begin
                st = ST_TOO_LONG;
                break;
            end
            for (int i = 1; i <= lab; i++) append_char(msg_mem[cur + i]);
            append_char(CHAR_DOT);
            cur += lab + 1;
        end
        push_expected(pack_word, name_len % 8, 1'b1, st, (st == ST_OK) ? resume : 0, name_len);
    endfunction

    task automatic check_field(input string fld, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
            errors++;
        end
    endtask

    // driver: predict on acceptance, then offer the next beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                if (cur_op.op == OP_WRITE) begin
                    msg_mem[cur_op.addr] = cur_op.val;
                    writes_seen++;
                end else begin
                    predict_walk(cur_op.addr, cur_op.mlen);
                    expands_seen++;
                end
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (msg_ops.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_op = msg_ops.pop_front();
                    in_bus.valid          <= 1'b1;
                    in_bus.operation      <= cur_op.op;
                    in_bus.address        <= cur_op.addr;
                    in_bus.byte_value     <= cur_op.val;
                    in_bus.message_length <= cur_op.mlen;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got_beat.chunk   = out_bus.name_chunk;
                got_beat.nbytes  = out_bus.chunk_bytes;
                got_beat.last    = out_bus.last;
                got_beat.status  = out_bus.status;
                got_beat.end_off = out_bus.end_offset;
                got_beat.nlen    = out_bus.name_length;
                beats_checked++;
                if (expected_chunks.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual chunk %h last %b",
                             $time, got_beat.chunk, got_beat.last);
                    errors++;
                end else begin
                    want_beat = expected_chunks.pop_front();
                    check_field("name_chunk", want_beat.chunk, got_beat.chunk);
                    check_field("chunk_bytes", 64'(want_beat.nbytes), 64'(got_beat.nbytes));
                    check_field("last", 64'(want_beat.last), 64'(got_beat.last));
                    check_field("status", 64'(want_beat.status), 64'(got_beat.status));
                    check_field("end_offset", 64'(want_beat.end_off), 64'(got_beat.end_off));
                    check_field("name_length", 64'(want_beat.nlen), 64'(got_beat.nlen));
                    if (want_beat.last) status_seen[want_beat.status]++;
                end
            end
            out_bus.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic void queue_write(int a, int v);
        t_msg_op m;
        m.op   = OP_WRITE;
        m.addr = ADDR_W'(a);
        m.val  = 8'(v);
        m.mlen = LEN_W'($urandom_range(1023));
        msg_ops.push_back(m);
        items_queued++;
    endfunction

    function automatic void queue_expand(int a, int len);
        t_msg_op m;
        m.op   = OP_EXPAND;
        m.addr = ADDR_W'(a);
        m.val  = 8'($urandom_range(255));
        m.mlen = LEN_W'(len);
        msg_ops.push_back(m);
        items_queued++;
    endfunction

    function automatic int pick_len();
        return ($urandom_range(4) == 0) ? int'($urandom_range(1023)) : MESSAGE_BYTES;
    endfunction

    function automatic void gen_sequence();
        int                kind;
        int                nlab;
        int                span;
        int                base;
        int                pos;
        int                lab_len [4];
        bit                to_prev;
        logic [ADDR_W-1:0] tgt;
        kind = $urandom_range(99);
        if (kind < 60 || kind >= 90) begin
            nlab = $urandom_range(1, 4);
            span = 0;
            for (int i = 0; i < nlab; i++) begin
                lab_len[i] = ($urandom_range(9) == 0) ? $urandom_range(13, 63)
                                                      : $urandom_range(1, 12);
                span += lab_len[i] + 1;
            end
            to_prev = (known_names.size() != 0) && ($urandom_range(1) == 1);
            span += to_prev ? 2 : 1;
            base = $urandom_range(MESSAGE_BYTES - 1 - span);
            pos  = base;
            for (int i = 0; i < nlab; i++) begin
                queue_write(pos, lab_len[i]);
                if (lab_len[i] <= 12 && $urandom_range(3) == 0) begin
                    for (int j = 1; j <= lab_len[i]; j++) queue_write(pos + j, $urandom_range(97, 122));
                end
                pos += lab_len[i] + 1;
            end
            if (to_prev) begin
                tgt = ADDR_W'(known_names[$urandom_range(known_names.size() - 1)]);
                queue_write(pos, {FMT_POINTER, 6'(tgt >> 8)});
                queue_write(pos + 1, tgt[7:0]);
            end else begin
                queue_write(pos, 0);
            end
            if (kind >= 90) begin
                case ($urandom_range(2))
                    0: queue_write(base, 8'h40 | $urandom_range(63));
                    1: queue_write(base, 8'h80 | $urandom_range(63));
                    default: begin
                        tgt = ADDR_W'(base);
                        queue_write(base, {FMT_POINTER, 6'(tgt >> 8)});
                        queue_write(base + 1, tgt[7:0]);
                    end
                endcase
            end
            known_names.push_back(base);
            queue_expand(base, pick_len());
        end else if (kind < 80) begin
            if ($urandom_range(1) == 1 && known_names.size() != 0)
                queue_expand(known_names[$urandom_range(known_names.size() - 1)], pick_len());
            else
                queue_expand($urandom_range(MESSAGE_BYTES - 1), pick_len());
        end else begin
            queue_write($urandom_range(MESSAGE_BYTES - 1), $urandom_range(255));
        end
    endfunction

    task automatic gen_items(input int n);
        items_queued = 0;
        while (items_queued < n) gen_sequence();
    endtask

    task automatic wait_drain();
        do @(posedge i_clk);
        while (msg_ops.size() != 0 || in_bus.valid || expected_chunks.size() != 0);
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        @(posedge i_clk);
        src_idle_pct <= src_pct;
        snk_idle_pct <= snk_pct;
    endtask

    initial begin
        i_rst_n               = 1'b0;
        in_bus.valid          = 1'b0;
        in_bus.operation      = OP_WRITE;
        in_bus.address        = '0;
        in_bus.byte_value     = '0;
        in_bus.message_length = '0;
        out_bus.ready         = 1'b0;
        hold_off              = 1'b0;
        src_idle_pct          = 0;
        snk_idle_pct          = 0;
        errors                = 0;
        writes_seen           = 0;
        expands_seen          = 0;
        beats_checked         = 0;
        items_queued          = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // load a whole message so every walk reads written bytes
        for (int a = 0; a < MESSAGE_BYTES; a++) queue_write(a, $urandom_range(255));

        queue_write(MESSAGE_BYTES - 1, 0);
        queue_expand(MESSAGE_BYTES - 1, 1023);
        queue_write(30, 2);
        queue_write(33, 0);
        queue_expand(30, MESSAGE_BYTES);
        queue_write(40, 1);
        queue_write(42, 8'hC0);
        queue_write(43, 30);
        queue_expand(40, MESSAGE_BYTES);
        queue_write(50, 8'h40);
        queue_write(51, 8'hBF);
        queue_expand(50, MESSAGE_BYTES);
        queue_expand(51, MESSAGE_BYTES);
        queue_expand(30, 0);
        queue_expand(30, 31);
        queue_expand(40, 43);
        queue_expand(30, 33);
        queue_write(60, 8'hC0);
        queue_write(61, 60);
        queue_expand(60, MESSAGE_BYTES);
        queue_write(200, 63);
        queue_write(264, 63);
        queue_write(328, 63);
        queue_write(392, 62);
        queue_write(455, 0);
        queue_expand(200, MESSAGE_BYTES);
        queue_write(100, 63);
        queue_write(164, 8'hC0);
        queue_write(165, 100);
        queue_expand(100, MESSAGE_BYTES);
        known_names.push_back(30);
        known_names.push_back(40);
        known_names.push_back(200);
        wait_drain();

        gen_items(45);
        wait_drain();

        // hold the result side while beats keep coming
        gen_items(25);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
        wait_drain();

        set_idling(79, 0);
        gen_items(55);
        wait_drain();

        set_idling(0, 79);
        gen_items(55);
        wait_drain();

        set_idling(6, 6);
        gen_items(55);
        wait_drain();

        repeat (64) @(posedge i_clk);
        if (expected_chunks.size() != 0) begin
            $display("%0t: %0d expected result beats never arrived", $time, expected_chunks.size());
            errors++;
        end
        $display("Covered %0d byte writes and %0d name expansions; %0d result beats checked",
                 writes_seen, expands_seen, beats_checked);
        $display("Closing status: ok %0d, past end %0d, reserved %0d, hop limit %0d, too long %0d",
                 status_seen[ST_OK], status_seen[ST_PAST_END], status_seen[ST_RESERVED],
                 status_seen[ST_HOPS], status_seen[ST_TOO_LONG]);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("%0t: timeout", $time);
        $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
src/dnd_pkg.sv
src/dnd_if.sv
src/dnd_ram.sv
src/dns_name_decompressor.sv
bench/tb_dns_name_decompressor.sv
